FILE: hw/rtl/pts_pkg.sv
// Package for the permutation to swap sequence unit.
// Holds the default table depth, the value width, the error codes, the sequencer states and the result type.
// No dependencies.
package pts_pkg;

	// Default number of table entries, which is also the longest permutation.
	localparam int unsigned MAX_ENTRIES_DEF = 64;

	// Width of the permutation value and of the row and index output fields.
	localparam int unsigned VAL_W = 6;

	// Error codes carried with each result item.
	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_RANGE = 2'd1,
		ERR_WALK  = 2'd2,
		ERR_FULL  = 2'd3
	} err_t;

	// Sequencer states.
	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

	// One result item as it leaves the sequencer.
	typedef struct packed {
		logic [VAL_W-1:0] swap_index;
		logic [VAL_W-1:0] row_position;
		logic             last_result;
		err_t             error_code;
	} res_t;

endpackage

FILE: hw/rtl/pts_table.sv
// Swap partner table: one write port and one registered read port.
// Depends on nothing; the depth comes from the top level.
module pts_table #(
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [AW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [AW-1:0] rd_data
);

	logic [AW-1:0] mem [DEPTH];

	// Entries are written once per row; reads hold their data until the next read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: hw/rtl/pts_seq.sv
// Walk sequencer: takes an item, follows the partner table one read per cycle
// and forms the result item. Depends on pts_pkg and the table ports.
module pts_seq #(
	parameter int unsigned MAX_ENTRIES = pts_pkg::MAX_ENTRIES_DEF,
	localparam int unsigned AW = $clog2(MAX_ENTRIES),
	localparam int unsigned RW = $clog2(MAX_ENTRIES + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [pts_pkg::VAL_W-1:0] perm_value,
	input  logic                     last_entry,
	input  logic [RW-1:0]            row,
	input  logic                     out_free,
	output logic                     fin,
	output pts_pkg::res_t            res,
	output logic                     rd_en,
	output logic [AW-1:0]            rd_addr,
	input  logic [AW-1:0]            rd_data,
	output logic                     wr_en,
	output logic [AW-1:0]            wr_addr,
	output logic [AW-1:0]            wr_data
);

	// Common width for index and row compares.
	localparam int unsigned XW = (RW > pts_pkg::VAL_W) ? RW : pts_pkg::VAL_W;

	pts_pkg::state_t state_q, state_next;
	logic [pts_pkg::VAL_W-1:0] value_q;
	logic last_q;
	logic first_q;
	logic [RW-1:0] reads_q;

	logic [XW-1:0] row_x, cur_idx, partner;
	logic full, oor, walk_go;

	// Current index is the entry itself before the first read, then the table data.
	assign row_x   = XW'(row);
	assign cur_idx = first_q ? XW'(value_q) : XW'(rd_data);
	assign full    = row >= RW'(MAX_ENTRIES);
	assign oor     = XW'(value_q) >= XW'(MAX_ENTRIES);
	assign walk_go = !full && !oor && (cur_idx < row_x) && (reads_q < RW'(MAX_ENTRIES));

	// Next state, table access and result forming.
	always_comb begin
		state_next = state_q;
		in_ready   = 1'b0;
		fin        = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = cur_idx[AW-1:0];
		partner    = cur_idx;
		res.error_code = pts_pkg::ERR_OK;
		if (full) begin
			partner = '0;
			res.error_code = pts_pkg::ERR_FULL;
		end else if (oor) begin
			partner = row_x;
			res.error_code = pts_pkg::ERR_RANGE;
		end else if (cur_idx < row_x) begin
			partner = row_x;
			res.error_code = pts_pkg::ERR_WALK;
		end
		res.swap_index   = partner[pts_pkg::VAL_W-1:0];
		res.row_position = row_x[pts_pkg::VAL_W-1:0];
		res.last_result  = last_q;
		unique case (state_q)
			pts_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_next = pts_pkg::ST_WALK;
				end
			end
			pts_pkg::ST_WALK: begin
				if (walk_go) begin
					rd_en = 1'b1;
				end else if (out_free) begin
					fin = 1'b1;
					state_next = pts_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = pts_pkg::ST_IDLE;
			end
		endcase
		wr_en   = fin && !full;
		wr_addr = row[AW-1:0];
		wr_data = partner[AW-1:0];
	end

	// State register and walk counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pts_pkg::ST_IDLE;
			first_q <= 1'b0;
			reads_q <= '0;
		end else begin
			state_q <= state_next;
			if (in_ready && in_valid) begin
				first_q <= 1'b1;
				reads_q <= '0;
			end else if (rd_en) begin
				first_q <= 1'b0;
				reads_q <= reads_q + RW'(1);
			end
		end
	end

	// Captured item fields.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			value_q <= perm_value;
			last_q  <= last_entry;
		end
	end

endmodule

FILE: hw/rtl/permutation_to_swap_sequence_unit.sv
// Turns a permutation, given one entry per item in row order with a flag on the
// last entry, into a sequence of in-place swaps: one result item per input item,
// carrying the swap partner, the row, the last flag and an error code. Each item
// walks the partner table through its single read port, up to MAX_ENTRIES reads,
// and the input is not ready while a walk is in progress. A finished result
// waits in an output register, so the next item can be taken meanwhile.
// The table needs no clearing after reset; the row counter starts at zero.
module permutation_to_swap_sequence_unit #(
	parameter int unsigned MAX_ENTRIES = pts_pkg::MAX_ENTRIES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [pts_pkg::VAL_W-1:0] perm_value,
	input  logic                      last_entry,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [pts_pkg::VAL_W-1:0] swap_index,
	output logic [pts_pkg::VAL_W-1:0] row_position,
	output logic                      last_result,
	output logic [1:0]                error_code
);

	localparam int unsigned AW = $clog2(MAX_ENTRIES);
	localparam int unsigned RW = $clog2(MAX_ENTRIES + 1);

	logic [RW-1:0] row_q;
	logic out_valid_q;
	pts_pkg::res_t res, res_q;
	logic fin, out_free;
	logic rd_en, wr_en;
	logic [AW-1:0] rd_addr, rd_data, wr_addr, wr_data;

	assign out_free = !out_valid_q || out_ready;

	pts_seq #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.perm_value(perm_value),
		.last_entry(last_entry),
		.row       (row_q),
		.out_free  (out_free),
		.fin       (fin),
		.res       (res),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	pts_table #(
		.DEPTH(MAX_ENTRIES)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Row counter: back to zero after the last entry, otherwise saturating count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (fin) begin
			if (res.last_result) begin
				row_q <= '0;
			end else if (row_q < RW'(MAX_ENTRIES)) begin
				row_q <= row_q + RW'(1);
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (fin) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign swap_index   = res_q.swap_index;
	assign row_position = res_q.row_position;
	assign last_result  = res_q.last_result;
	assign error_code   = res_q.error_code;

endmodule
